[rtl/grbm_pkg.sv]
// shared types, field widths, band edges and band classification
// for the gain row best-match lookup; no dependencies
`timescale 1ns / 1ps

package grbm_pkg;

    localparam int OP_W      = 2;
    localparam int ANT_W     = 24;
    localparam int FREQ_W    = 27;
    localparam int TIME_W    = 32;
    localparam int BAND_W    = 4;
    localparam int ROW_IDX_W = 12;
    localparam int ST_W      = 2;
    localparam int EDGE_CNT  = 12;

    localparam int IN_BITS  = OP_W + ANT_W + FREQ_W + 3 * TIME_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + ROW_IDX_W + 1 + ST_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int DEF_MAX_ROWS   = 4096;
    localparam int DEF_BAND_COUNT = 11;

    localparam logic [FREQ_W-1:0] BAND_EDGE [EDGE_CNT] = '{
        27'd0,        27'd450000,   27'd900000,   27'd2000000,
        27'd4000000,  27'd6000000,  27'd10000000, 27'd18000000,
        27'd26000000, 27'd40000000, 27'd70000000, 27'd100000000
    };

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_BAND = 2'd2
    } t_status;

    typedef struct packed {
        logic              ok;
        logic [BAND_W-1:0] band;
    } t_band;

    typedef struct packed {
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] win_end;
        logic [ANT_W-1:0]  ant;
        logic [FREQ_W-1:0] freq;
        logic [BAND_W-1:0] band;
    } t_row;

    typedef struct packed {
        logic [TIME_W-1:0] qtime;
        logic [FREQ_W-1:0] freq;
        logic [ANT_W-1:0]  ant;
        logic [BAND_W-1:0] band;
    } t_query;

    typedef struct packed {
        logic              vld;
        logic              hit;
        logic              db;
        logic [FREQ_W-1:0] df;
    } t_eval;

    // packed so that found lands in bit 0
    typedef struct packed {
        t_status              status;
        logic                 band_distance;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 found;
    } t_result;

    function automatic t_band classify_band(input logic [FREQ_W-1:0] f,
                                            input int band_count);
        t_band res;
        res = '0;
        for (int i = 0; i < EDGE_CNT - 1; i++) begin
            if (i < band_count && f > BAND_EDGE[i] && f < BAND_EDGE[i+1]) begin
                res.ok   = 1'b1;
                res.band = BAND_W'(i);
            end
        end
        return res;
    endfunction

endpackage

[rtl/gain_row_best_match_lookup.sv]
// channel   dir  beat fields (lsb first)
// s_axis    in   operation, antenna, freq_khz, query_time, window_start, window_end
// m_axis    out  found, row_index, band_distance, status
//
// load, clear and unused codes: the result is registered, then moved to the output register once it is free.
// query: one table row read per cycle from the row memory during the scan;
// the result is then moved to the output register once it is free.
// reset clears the row count and control; row memory contents are kept.
// input ready is low from an accepted beat until its result sits in the output register;
// the output register holds its beat until taken.
// top level of the gain row best-match lookup; uses grbm_pkg and grbm_row_eval
`timescale 1ns / 1ps

module gain_row_best_match_lookup #(
    parameter int MAX_ROWS   = grbm_pkg::DEF_MAX_ROWS,
    parameter int BAND_COUNT = grbm_pkg::DEF_BAND_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // operation, antenna, freq_khz, query_time, window_start, window_end
    input  logic [grbm_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // found, row_index, band_distance, status
    output logic [grbm_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import grbm_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_addr;
    t_query            r_query;
    logic              r_have;
    logic [AW-1:0]     r_best;
    logic              r_best_db;
    logic [FREQ_W-1:0] r_best_df;
    t_result           r_res;
    t_result           n_res;
    t_result           r_out;
    logic              r_out_vld;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    t_row              r_rd_row;
    t_row              mem [MAX_ROWS];

    logic [OP_W-1:0]   in_op;
    t_row              in_row;
    logic [TIME_W-1:0] in_qtime;
    t_band             in_band;
    logic              accept;
    logic              full;
    logic              issue;
    logic              out_free;
    t_eval             eval;
    logic [AW-1:0]     eval_idx;
    logic              better;

    always_comb begin
        in_op            = i_s_axis_tdata[1:0];
        in_row.ant       = i_s_axis_tdata[25:2];
        in_row.freq      = i_s_axis_tdata[52:26];
        in_qtime         = i_s_axis_tdata[84:53];
        in_row.win_start = i_s_axis_tdata[116:85];
        in_row.win_end   = i_s_axis_tdata[148:117];
        in_band          = classify_band(in_row.freq, BAND_COUNT);
        in_row.band      = in_band.ok ? in_band.band : '0;
    end

    // result of a beat that needs no scan
    always_comb begin
        n_res = '0;
        if (in_op == OP_LOAD) begin
            if (full) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.row_index = ROW_IDX_W'(r_count);
            end
        end else if ((in_op == OP_QUERY) && !in_band.ok) begin
            n_res.status = ST_NO_BAND;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count >= CW'(MAX_ROWS));
    assign issue           = (r_state == S_SCAN) && (r_addr < r_count);
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign better          = eval.vld && eval.hit
                          && (!r_have || (eval.db < r_best_db)
                              || ((eval.db == r_best_db) && (eval.df < r_best_df)));

    // row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && (in_op == OP_LOAD) && !full) begin
            mem[r_count[AW-1:0]] <= in_row;
        end
        r_rd_row <= mem[r_addr[AW-1:0]];
    end

    grbm_row_eval #(
        .IDX_W (AW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_row   (r_rd_row),
        .i_query (r_query),
        .o_eval  (eval),
        .o_idx   (eval_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_have    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_rd_idx <= r_addr[AW-1:0];
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res <= n_res;
                        unique case (in_op)
                            OP_LOAD: begin
                                if (!full) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            OP_QUERY: begin
                                if (!in_band.ok) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_query.qtime <= in_qtime;
                                    r_query.freq  <= in_row.freq;
                                    r_query.ant   <= in_row.ant;
                                    r_query.band  <= in_band.band;
                                    r_addr        <= '0;
                                    r_have        <= 1'b0;
                                    r_state       <= S_SCAN;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (better) begin
                        r_have    <= 1'b1;
                        r_best    <= eval_idx;
                        r_best_db <= eval.db;
                        r_best_df <= eval.df;
                    end
                    if (!issue && !r_rd_vld && !eval.vld) begin
                        r_res.found         <= r_have;
                        r_res.row_index     <= r_have ? ROW_IDX_W'(r_best) : '0;
                        r_res.band_distance <= r_have && r_best_db;
                        r_res.status        <= ST_OK;
                        r_state             <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out);

endmodule

[rtl/grbm_row_eval.sv]
// per-row match unit: window, antenna and band checks plus band and
// frequency distance, one row per cycle, registered; uses grbm_pkg
`timescale 1ns / 1ps

module grbm_row_eval #(
    parameter int IDX_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [IDX_W-1:0]     i_idx,
    input  grbm_pkg::t_row       i_row,
    input  grbm_pkg::t_query     i_query,
    output grbm_pkg::t_eval      o_eval,
    output logic [IDX_W-1:0]     o_idx
);
    import grbm_pkg::*;

    logic              win_ok;
    logic              ant_ok;
    logic              band_ok;
    logic              db;
    logic [FREQ_W-1:0] df;
    t_eval             r_eval;
    logic [IDX_W-1:0]  r_idx;

    always_comb begin
        win_ok = (i_query.qtime > i_row.win_start) && (i_query.qtime <= i_row.win_end);
        ant_ok = (i_query.ant == i_row.ant);
        band_ok = (i_row.band == i_query.band)
               || (i_row.band == i_query.band + BAND_W'(1))
               || (i_query.band == i_row.band + BAND_W'(1));
        db = (i_row.band != i_query.band);
        df = (i_row.freq > i_query.freq) ? i_row.freq - i_query.freq
                                         : i_query.freq - i_row.freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval.vld <= 1'b0;
        end else begin
            r_eval.vld <= i_vld;
        end
        r_eval.hit <= win_ok && ant_ok && band_ok;
        r_eval.db  <= db;
        r_eval.df  <= df;
        r_idx      <= i_idx;
    end

    assign o_eval = r_eval;
    assign o_idx  = r_idx;

endmodule
